[rtl/core/hcrt_pkg.sv]
// Shared types and constants of the hop count route table.
package hcrt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int MODE_W    = 2;
    localparam int ADDR_W    = 32;
    localparam int MAC_W     = 48;
    localparam int HOPS_W    = 8;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30);

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_STALE  = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_MISS    = 2'd1,
        ST_REMOVED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [MAC_W-1:0]  gw_mac;
        logic [HOPS_W-1:0] hops;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] dest_address;
        logic [MAC_W-1:0]  new_next_hop;
        logic [HOPS_W-1:0] hop_count;
        logic [TIME_W-1:0] now_seconds;
    } t_item;

    typedef struct packed {
        logic              found;
        logic [MAC_W-1:0]  next_hop_out;
        logic [HOPS_W-1:0] hop_out;
        t_status           status;
    } t_result;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CMP   = 6'b000100,
        S_SH_RD = 6'b001000,
        S_SH_WR = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

endpackage

[rtl/core/hcrt_if.sv]
// Valid/ready channel interfaces for request and result beats.
interface hcrt_req_if;
    logic                     valid;
    logic                     ready;
    logic [hcrt_pkg::MODE_W-1:0] mode;
    logic [hcrt_pkg::ADDR_W-1:0] dest_address;
    logic [hcrt_pkg::MAC_W-1:0]  new_next_hop;
    logic [hcrt_pkg::HOPS_W-1:0] hop_count;
    logic [hcrt_pkg::TIME_W-1:0] now_seconds;

    modport source (output valid, mode, dest_address, new_next_hop, hop_count, now_seconds,
                    input ready);
    modport sink   (input valid, mode, dest_address, new_next_hop, hop_count, now_seconds,
                    output ready);
endinterface

interface hcrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [hcrt_pkg::MAC_W-1:0]    next_hop_out;
    logic [hcrt_pkg::HOPS_W-1:0]   hop_out;
    logic [hcrt_pkg::STATUS_W-1:0] status;

    modport source (output valid, found, next_hop_out, hop_out, status, input ready);
    modport sink   (input valid, found, next_hop_out, hop_out, status, output ready);
endinterface

[rtl/core/hop_count_route_table.sv]
// Top level of the hop count route table: sequencer around one entry RAM.
//
// Usage: request beats arrive on i_item (mode, destination, offered next hop,
// offered hop count, current time); each gives exactly one result beat on
// o_result (found, next hop, hop count, status). The user writes the stale
// timeout via i_cfg_we / i_cfg_wdata only while idle; this is not enforced.
//
// Entries live packed from slot 0 in a single RAM with a registered read; a
// fill count marks how many slots are in use. An item is handled by a linear
// scan that reads and then compares each used slot in turn; a hit ends the
// scan, and a miss falls through after the last used slot. Removing a stale
// entry then moves every later entry forward one slot, each by a read and a
// write, and lowers the fill count. The scan goes through the one RAM port.
// One item is in flight at a time: i_item.ready is high only while the
// sequencer is idle.
//
// The result sits in an output register, so a new request beat is taken while
// the previous result waits; a stalled receiver holds the result steady and the
// sequencer waits before it overwrites it. Reset empties the table (fill count
// zero, no clearing pass needed) and loads a stale timeout of 30 seconds.
module hop_count_route_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hcrt_pkg::TIMEOUT_W-1:0]  i_cfg_wdata,
    hcrt_req_if.sink                        i_item,
    hcrt_rsp_if.source                      o_result
);
    import hcrt_pkg::*;

    t_state                r_state,   n_state;
    logic [CNT_W-1:0]      r_idx,     n_idx;
    logic [CNT_W-1:0]      r_count,   n_count;
    logic [TIMEOUT_W-1:0]  r_timeout;
    t_item                 r_item,    n_item;
    t_result               r_pend,    n_pend;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out,     n_out;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    t_entry                ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    t_entry                rd_entry;
    logic [CNT_W-1:0]      idx_inc;
    logic [TIME_W:0]       stale_limit;

    hcrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry    = t_entry'(ram_rdata);
    assign idx_inc     = r_idx + CNT_W'(1);
    // Timestamp plus timeout carries into a spare bit so it never wraps.
    assign stale_limit = {1'b0, rd_entry.stamp} + (TIME_W + 1)'(r_timeout);

    assign i_item.ready = (r_state == S_IDLE);

    // The sequencer issues one RAM access at a time and never uses read data
    // of a slot written in the same cycle, so no forwarding path is needed.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_item      = r_item;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[IDX_W-1:0];
        ram_wdata   = rd_entry;
        ram_raddr   = r_idx[IDX_W-1:0];

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_item.mode         = i_item.mode;
                    n_item.dest_address = i_item.dest_address;
                    n_item.new_next_hop = i_item.new_next_hop;
                    n_item.hop_count    = i_item.hop_count;
                    n_item.now_seconds  = i_item.now_seconds;
                    n_idx               = '0;
                    n_state             = S_READ;
                end
            end
            S_READ: begin
                if (r_idx == r_count) begin
                    // Scanned every used slot without a match.
                    n_pend.found        = 1'b0;
                    n_pend.next_hop_out = '0;
                    n_pend.hop_out      = '0;
                    n_pend.status       = ST_MISS;
                    if (r_item.mode == MODE_UPDATE) begin
                        if (r_count < CNT_W'(ENTRIES)) begin
                            ram_we              = 1'b1;
                            ram_waddr           = r_count[IDX_W-1:0];
                            ram_wdata.addr      = r_item.dest_address;
                            ram_wdata.gw_mac    = r_item.new_next_hop;
                            ram_wdata.hops      = r_item.hop_count;
                            ram_wdata.stamp     = r_item.now_seconds;
                            n_count             = r_count + CNT_W'(1);
                            n_pend.next_hop_out = r_item.new_next_hop;
                            n_pend.hop_out      = r_item.hop_count;
                            n_pend.status       = ST_DONE;
                        end else begin
                            n_pend.status = ST_FULL;
                        end
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (rd_entry.addr == r_item.dest_address) begin
                    n_pend.found        = 1'b1;
                    n_pend.next_hop_out = rd_entry.gw_mac;
                    n_pend.hop_out      = rd_entry.hops;
                    n_pend.status       = ST_DONE;
                    n_state             = S_DONE;
                    if (r_item.mode == MODE_UPDATE) begin
                        // Only a strictly better route replaces the entry.
                        if (r_item.hop_count < rd_entry.hops) begin
                            ram_we              = 1'b1;
                            ram_wdata.gw_mac    = r_item.new_next_hop;
                            ram_wdata.hops      = r_item.hop_count;
                            ram_wdata.stamp     = r_item.now_seconds;
                            n_pend.next_hop_out = r_item.new_next_hop;
                            n_pend.hop_out      = r_item.hop_count;
                        end
                    end else if (r_item.mode == MODE_STALE) begin
                        if ({1'b0, r_item.now_seconds} > stale_limit) begin
                            n_pend.status = ST_REMOVED;
                            n_state       = S_SH_RD;
                        end
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_READ;
                end
            end
            S_SH_RD: begin
                // Move the following entry down into the current slot.
                if (idx_inc == r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    ram_raddr = idx_inc[IDX_W-1:0];
                    n_state   = S_SH_WR;
                end
            end
            S_SH_WR: begin
                ram_we    = 1'b1;
                ram_wdata = rd_entry;
                n_idx     = idx_inc;
                n_state   = S_SH_RD;
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.found        = r_out.found;
    assign o_result.next_hop_out = r_out.next_hop_out;
    assign o_result.hop_out      = r_out.hop_out;
    assign o_result.status       = r_out.status;
endmodule

[rtl/core/hcrt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module hcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
